// ===== src/positional_insert_delete_array_core_assert.svh =====
// Assertion macros shared by the core. Each clocks on clk_i and is disabled in reset.
`ifndef POSITIONAL_INSERT_DELETE_ARRAY_CORE_ASSERT_SVH
`define POSITIONAL_INSERT_DELETE_ARRAY_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define PIDA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define PIDA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PIDA_ASSERT_SAME(lbl, ante, cons, msg)
`define PIDA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== src/pida_pkg.sv =====
`default_nettype none

package pida_pkg;

  localparam int DATA_W        = 32;
  localparam int POS_W         = 8;
  localparam int DEPTH_DEFAULT = 128;

  typedef enum logic [1:0] {
    FUNC_CLEAR  = 2'd0,
    FUNC_INSERT = 2'd1,
    FUNC_DELETE = 2'd2,
    FUNC_READ   = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_RANGE = 2'd2
  } status_e;

  typedef enum logic {
    ST_IDLE,
    ST_COLLECT
  } state_e;

  typedef struct packed {
    func_e                     func;
    logic [POS_W-1:0]          position;
    logic signed [DATA_W-1:0]  value;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0]  read_value;
    logic [7:0]                element_count;
    status_e                   status;
  } rsp_t;

  // Broadcast to every cell of the row.
  typedef struct packed {
    logic                      ins;
    logic                      del;
    logic                      cap;
    logic                      shift;
    logic [POS_W-1:0]          position;
    logic signed [DATA_W-1:0]  value;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== src/pida_cell.sv =====
`default_nettype none

module pida_cell import pida_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT,
  parameter int INDEX = 0
) (
  input  logic                     clk_i,
  input  cell_ctrl_t               ctrl_i,
  input  logic signed [DATA_W-1:0] left_i,
  input  logic signed [DATA_W-1:0] right_i,
  input  logic signed [DATA_W-1:0] coll_right_i,
  output logic signed [DATA_W-1:0] elem_o,
  output logic signed [DATA_W-1:0] coll_o
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CW    = (IDX_W > POS_W) ? IDX_W : POS_W;
  localparam logic [CW-1:0] IdxC = CW'(INDEX);

  logic signed [DATA_W-1:0] elem_d, elem_q;
  logic signed [DATA_W-1:0] coll_d, coll_q;
  logic [CW-1:0]            pos_ext;
  logic                     hit, above;

  assign pos_ext = CW'(ctrl_i.position);
  assign hit     = (IdxC == pos_ext);
  assign above   = (IdxC > pos_ext);

  always_comb begin
    elem_d = elem_q;
    if (ctrl_i.ins && hit) begin
      elem_d = ctrl_i.value;
    end else if (ctrl_i.ins && above) begin
      elem_d = left_i;
    end else if (ctrl_i.del && (hit || above)) begin
      elem_d = right_i;
    end
  end

  // Capture the target beat, then walk it toward cell zero.
  always_comb begin
    coll_d = coll_q;
    if (ctrl_i.cap) begin
      coll_d = hit ? elem_q : '0;
    end else if (ctrl_i.shift) begin
      coll_d = coll_right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    elem_q <= elem_d;
    coll_q <= coll_d;
  end

  assign elem_o = elem_q;
  assign coll_o = coll_q;

endmodule

`default_nettype wire

// ===== src/positional_insert_delete_array_core.sv =====
`default_nettype none
// Ordered array of signed 32-bit elements kept in a row of cells, one element per cell.
// Command channel: req_i (func, position, value) is taken at a rising edge with start_i
// high and busy_o low. Result channel: rsp_o (read_value, element_count, status) is
// valid for exactly one cycle while result_valid_o is high; the receiver cannot stall,
// so every result must be taken in that cycle.
// Insert and delete shift the cells at and above the position in the same cycle as the command is taken.
// Clear, insert and flagged commands strobe their result in the cycle after acceptance.
// Read and delete capture the addressed element and hand it down the row one cell
// per cycle, then register it as their result once it reaches cell zero; busy_o
// stays high meanwhile. The next command may be taken in the cycle the result shows.
// Clear and insert can be taken one command per cycle while busy_o is low; read and
// delete block new commands while the collect chain hops the element to cell zero.
// Reset clears the element count and the control state; the element cells are not
// cleared and only entries below the count are ever read.
`include "positional_insert_delete_array_core_assert.svh"

module positional_insert_delete_array_core import pida_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  req_t req_i,
  output logic busy_o,
  output logic result_valid_o,
  output rsp_t rsp_o
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam logic [CMP_W-1:0] DepthC = CMP_W'(DEPTH);

  state_e             state_d, state_q;
  logic [CNT_W-1:0]   count_d, count_q;
  logic [POS_W-1:0]   remain_d, remain_q;
  logic               valid_d, valid_q;
  rsp_t               rsp_d, rsp_q;

  logic               accept, ins_ok, del_ok, rd_ok, cap_ok;
  logic               busy, shift_en, finish;
  logic [CMP_W-1:0]   cnt_ext, pos_ext, cnt_new_ext;
  status_e            status;
  cell_ctrl_t         ctrl;

  logic signed [DATA_W-1:0] elem [DEPTH];
  logic signed [DATA_W-1:0] coll [DEPTH];

  assign accept  = start_i && !busy;
  assign cnt_ext = CMP_W'(count_q);
  assign pos_ext = CMP_W'(req_i.position);

  // Decode and range checks.
  always_comb begin
    ins_ok = 1'b0;
    del_ok = 1'b0;
    rd_ok  = 1'b0;
    status = STATUS_OK;
    case (req_i.func)
      FUNC_CLEAR: begin
        status = STATUS_OK;
      end
      FUNC_INSERT: begin
        if (cnt_ext == DepthC) begin
          status = STATUS_FULL;
        end else if (pos_ext > cnt_ext) begin
          status = STATUS_RANGE;
        end else begin
          ins_ok = 1'b1;
        end
      end
      FUNC_DELETE: begin
        if (pos_ext >= cnt_ext) begin
          status = STATUS_RANGE;
        end else begin
          del_ok = 1'b1;
        end
      end
      FUNC_READ: begin
        if (pos_ext >= cnt_ext) begin
          status = STATUS_RANGE;
        end else begin
          rd_ok = 1'b1;
        end
      end
      default: begin
        status = STATUS_OK;
      end
    endcase
  end

  assign cap_ok = del_ok || rd_ok;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && cap_ok) begin
          state_d = ST_COLLECT;
        end
      end
      ST_COLLECT: begin
        if (remain_q == '0) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State outputs.
  always_comb begin
    busy     = 1'b0;
    shift_en = 1'b0;
    finish   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        busy = 1'b0;
      end
      ST_COLLECT: begin
        busy     = 1'b1;
        shift_en = (remain_q != '0);
        finish   = (remain_q == '0);
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

  always_comb begin
    count_d  = count_q;
    remain_d = remain_q;
    valid_d  = 1'b0;
    rsp_d    = rsp_q;
    if (accept) begin
      if (req_i.func == FUNC_CLEAR) begin
        count_d = '0;
      end else if (ins_ok) begin
        count_d = count_q + CNT_W'(1);
      end else if (del_ok) begin
        count_d = count_q - CNT_W'(1);
      end
      cnt_new_ext         = CMP_W'(count_d);
      rsp_d.read_value    = '0;
      rsp_d.element_count = cnt_new_ext[7:0];
      rsp_d.status        = status;
      remain_d            = req_i.position;
      valid_d             = !cap_ok;
    end else begin
      cnt_new_ext = cnt_ext;
      if (shift_en) begin
        remain_d = remain_q - POS_W'(1);
      end else if (finish) begin
        rsp_d.read_value = coll[0];
        valid_d          = 1'b1;
      end
    end
  end

  always_comb begin
    ctrl.ins      = accept && ins_ok;
    ctrl.del      = accept && del_ok;
    ctrl.cap      = accept && cap_ok;
    ctrl.shift    = shift_en;
    ctrl.position = req_i.position;
    ctrl.value    = req_i.value;
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [DATA_W-1:0] left_w, right_w, coll_right_w;
    if (g == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = elem[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_w      = '0;
      assign coll_right_w = '0;
    end else begin : g_mid_r
      assign right_w      = elem[g+1];
      assign coll_right_w = coll[g+1];
    end
    pida_cell #(
      .DEPTH (DEPTH),
      .INDEX (g)
    ) u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .left_i       (left_w),
      .right_i      (right_w),
      .coll_right_i (coll_right_w),
      .elem_o       (elem[g]),
      .coll_o       (coll[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      count_q  <= '0;
      remain_q <= '0;
      valid_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      remain_q <= remain_d;
      valid_q  <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign busy_o         = busy;
  assign result_valid_o = valid_q;
  assign rsp_o          = rsp_q;

  `PIDA_ASSERT_NEXT(a_quick_result, accept && !cap_ok, result_valid_o, "result beat missing")
  `PIDA_ASSERT_NEXT(a_collect_busy, accept && cap_ok, busy_o && !result_valid_o, "collect not busy")
  `PIDA_ASSERT_SAME(a_result_idle, result_valid_o, !busy_o, "result beat while busy")
  `PIDA_ASSERT_SAME(a_count_bound, 1'b1, cnt_ext <= DepthC, "element count above depth")

endmodule

`default_nettype wire

// ===== sim/tb_positional_insert_delete_array_core.sv =====
`timescale 1ns / 1ps

module tb_positional_insert_delete_array_core;
  import pida_pkg::*;

  localparam int DEPTH       = DEPTH_DEFAULT;
  localparam int RAND_ITEMS  = 400;
  localparam int STALL_MAX   = 2000;
  localparam int TAIL_CYCLES = DEPTH + 16;

  logic clk_i   = 1'b0;
  logic rst_ni  = 1'b0;
  logic start_i = 1'b0;
  req_t req_i   = '0;
  logic busy_o;
  logic result_valid_o;
  rsp_t rsp_o;

  positional_insert_delete_array_core #(
    .DEPTH(DEPTH)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .req_i         (req_i),
    .busy_o        (busy_o),
    .result_valid_o(result_valid_o),
    .rsp_o         (rsp_o)
  );

  req_t                     cmd_q[$];
  rsp_t                     due_rsp_q[$];
  logic signed [DATA_W-1:0] shadow_elems[DEPTH];
  int                       shadow_count = 0;
  int                       plan_count   = 0;
  int                       taken_cnt    = 0;
  int                       error_cnt    = 0;
  int                       stall_cycles = 0;
  req_t                     noise_req;
  rsp_t                     want_rsp;

  // No idling while this window of beats goes through.
  wire no_idle = (taken_cnt >= 180) && (taken_cnt < 300);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Apply one command to the shadow array and return the response it owes.
  function automatic rsp_t apply_cmd(req_t c);
    rsp_t r;
    int   i;
    r.read_value = '0;
    r.status     = STATUS_OK;
    case (c.func)
      FUNC_CLEAR: shadow_count = 0;
      FUNC_INSERT: begin
        if (shadow_count >= DEPTH) begin
          r.status = STATUS_FULL;
        end else if (int'(c.position) > shadow_count) begin
          r.status = STATUS_RANGE;
        end else begin
          for (i = shadow_count; i > int'(c.position); i--) shadow_elems[i] = shadow_elems[i-1];
          shadow_elems[c.position] = c.value;
          shadow_count++;
        end
      end
      FUNC_DELETE: begin
        if (int'(c.position) >= shadow_count) begin
          r.status = STATUS_RANGE;
        end else begin
          r.read_value = shadow_elems[c.position];
          for (i = int'(c.position); i + 1 < shadow_count; i++) shadow_elems[i] = shadow_elems[i+1];
          shadow_count--;
        end
      end
      default: begin
        if (int'(c.position) >= shadow_count) r.status = STATUS_RANGE;
        else r.read_value = shadow_elems[c.position];
      end
    endcase
    r.element_count = 8'(shadow_count);
    return r;
  endfunction

  // Queue a command and track the count it leaves, to aim later positions.
  function automatic void push_cmd(func_e f, logic [7:0] pos, logic [31:0] v);
    req_t c;
    c.func     = f;
    c.position = pos;
    c.value    = v;
    cmd_q.push_back(c);
    case (f)
      FUNC_CLEAR:  plan_count = 0;
      FUNC_INSERT: if (plan_count < DEPTH && int'(pos) <= plan_count) plan_count++;
      FUNC_DELETE: if (int'(pos) < plan_count) plan_count--;
      default: ;
    endcase
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic report_error(input string what);
    $display("ERROR at %0t ns: %s", $time, what);
    error_cnt++;
  endtask

  task automatic wait_drained();
    while (cmd_q.size() != 0 || start_i || due_rsp_q.size() != 0) @(posedge clk_i);
  endtask

  // Driver: hold a beat while busy, otherwise send the next one or idle.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        due_rsp_q.push_back(apply_cmd(req_i));
        taken_cnt <= taken_cnt + 1;
      end
      if (!start_i || !busy_o) begin
        if (cmd_q.size() != 0 && (no_idle || $urandom_range(0, 99) >= 14)) begin
          req_i   <= cmd_q.pop_front();
          start_i <= 1'b1;
        end else begin
          noise_req.func     = func_e'(2'($urandom_range(0, 3)));
          noise_req.position = 8'($urandom);
          noise_req.value    = $urandom;
          req_i   <= noise_req;
          start_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobed result must match the oldest response due.
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (due_rsp_q.size() == 0) begin
        report_error("result strobed with no response due");
      end else begin
        want_rsp = due_rsp_q.pop_front();
        if (rsp_o.read_value !== want_rsp.read_value)
          report_error($sformatf("read_value got %0d want %0d",
                                 rsp_o.read_value, want_rsp.read_value));
        if (rsp_o.element_count !== want_rsp.element_count)
          report_error($sformatf("element_count got %0d want %0d",
                                 rsp_o.element_count, want_rsp.element_count));
        if (rsp_o.status !== want_rsp.status)
          report_error($sformatf("status got %0d want %0d", rsp_o.status, want_rsp.status));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || result_valid_o) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_MAX) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    int    n;
    int    seg;
    int    k;
    int    r;
    bit    filled;
    func_e f;
    logic [7:0] pos;

    filled = 1'b0;

    // Empty array, then front, middle and append inserts.
    push_cmd(FUNC_READ,   8'd0,   pick_value());
    push_cmd(FUNC_DELETE, 8'd0,   pick_value());
    push_cmd(FUNC_INSERT, 8'd1,   32'h1234_5678);
    push_cmd(FUNC_INSERT, 8'd0,   32'h7FFF_FFFF);
    push_cmd(FUNC_INSERT, 8'd0,   32'h8000_0000);
    push_cmd(FUNC_INSERT, 8'd2,   32'hFFFF_FFFF);
    push_cmd(FUNC_INSERT, 8'd1,   32'h0000_0000);
    for (k = 0; k < 4; k++) push_cmd(FUNC_READ, 8'(k), pick_value());
    push_cmd(FUNC_READ,   8'd4,   pick_value());
    push_cmd(FUNC_READ,   8'd255, pick_value());
    push_cmd(FUNC_DELETE, 8'd1,   pick_value());
    push_cmd(FUNC_DELETE, 8'd2,   pick_value());
    push_cmd(FUNC_DELETE, 8'd0,   pick_value());
    push_cmd(FUNC_INSERT, 8'd255, pick_value());
    push_cmd(FUNC_CLEAR,  8'd0,   pick_value());
    push_cmd(FUNC_READ,   8'd0,   pick_value());
    push_cmd(FUNC_INSERT, 8'd0,   32'h5555_5555);
    push_cmd(FUNC_INSERT, 8'd1,   32'hAAAA_AAAA);
    push_cmd(FUNC_DELETE, 8'd128, pick_value());
    push_cmd(FUNC_READ,   8'd1,   pick_value());

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Hold off until the directed beats have all answered.
    wait_drained();

    n = 0;
    while (n < RAND_ITEMS) begin
      if (!filled && n >= 120) begin
        filled = 1'b1;
        while (plan_count < DEPTH) begin
          push_cmd(FUNC_INSERT, 8'($urandom_range(0, plan_count)), pick_value());
          n++;
        end
        // Full array: full flag wins over the position check.
        push_cmd(FUNC_INSERT, 8'(DEPTH),     pick_value());
        push_cmd(FUNC_INSERT, 8'd0,          pick_value());
        push_cmd(FUNC_INSERT, 8'd200,        pick_value());
        push_cmd(FUNC_READ,   8'(DEPTH - 1), pick_value());
        push_cmd(FUNC_READ,   8'(DEPTH),     pick_value());
        push_cmd(FUNC_DELETE, 8'(DEPTH - 1), pick_value());
        push_cmd(FUNC_INSERT, 8'(DEPTH - 1), pick_value());
        push_cmd(FUNC_INSERT, 8'(DEPTH),     pick_value());
        push_cmd(FUNC_DELETE, 8'd0,          pick_value());
        n += 9;
        wait_drained();
      end else begin
        seg = $urandom_range(0, 9);
        for (k = 0; k < ((seg == 0) ? 5 : 20); k++) begin
          r = $urandom_range(0, 99);
          if (seg == 0) begin
            f   = func_e'(2'($urandom_range(0, 3)));
            pos = 8'($urandom);
          end else begin
            if (r < 48)      f = FUNC_INSERT;
            else if (r < 72) f = FUNC_DELETE;
            else if (r < 97) f = FUNC_READ;
            else             f = FUNC_CLEAR;
            if ($urandom_range(0, 99) < 15) begin
              pos = 8'($urandom);
            end else if (f == FUNC_INSERT) begin
              pos = 8'($urandom_range(0, plan_count));
            end else begin
              pos = (plan_count == 0) ? 8'd0 : 8'($urandom_range(0, plan_count - 1));
            end
          end
          push_cmd(f, pos, pick_value());
          n++;
        end
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (error_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== positional_insert_delete_array_core.f =====
+incdir+src
src/pida_pkg.sv
src/pida_cell.sv
src/positional_insert_delete_array_core.sv
sim/tb_positional_insert_delete_array_core.sv
